[design/umpj_pkg.sv]
// ----------------------------------------------------------------------------
// umpj_pkg
// Shared types, constants and helpers for the unicycle motion predictor.
// ----------------------------------------------------------------------------
package umpj_pkg;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_MU_X       = 3'd0,
    REG_MU_Y       = 3'd1,
    REG_MU_HEADING = 3'd2,
    REG_MU_SPEED   = 3'd3,
    REG_MU_TURN    = 3'd4
  } reg_idx_e;

  localparam int unsigned         MaxSteps     = 30;
  localparam logic [31:0]         InvTwoPiQ32  = 32'd683565276;
  localparam logic signed [33:0]  CordicGain   = 34'sd652032874;
  localparam logic [40:0]         MagCap       = 41'h100_0000_0000;

  // Input word
  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] heading;
    logic signed [31:0] speed;
    logic signed [31:0] turn_rate;
    logic        [31:0] time_step;
  } in_word_t;

  // Result word
  typedef struct packed {
    logic signed [31:0] next_x;
    logic signed [31:0] next_y;
    logic signed [31:0] next_heading;
    logic signed [31:0] next_speed;
    logic signed [31:0] next_turn;
    logic signed [31:0] jac_x_by_heading;
    logic signed [31:0] jac_x_by_speed;
    logic signed [31:0] jac_y_by_heading;
    logic signed [31:0] jac_y_by_speed;
    logic        [30:0] jac_heading_by_turn;
  } out_word_t;

  // Configuration write word
  typedef struct packed {
    logic [2:0]  index;
    logic [31:0] data;
  } cfg_word_t;

  // Arctangent of 2^-i in Q32 turns
  function automatic logic [31:0] atan_turns(input logic [4:0] i);
    logic [31:0] r;
    case (i)
      5'd0:  r = 32'h20000000;  5'd1:  r = 32'h12E4051E;
      5'd2:  r = 32'h09FB385B;  5'd3:  r = 32'h051111D4;
      5'd4:  r = 32'h028B0D43;  5'd5:  r = 32'h0145D7E1;
      5'd6:  r = 32'h00A2F61E;  5'd7:  r = 32'h00517C55;
      5'd8:  r = 32'h0028BE53;  5'd9:  r = 32'h00145F2F;
      5'd10: r = 32'h000A2F98;  5'd11: r = 32'h000517CC;
      5'd12: r = 32'h00028BE6;  5'd13: r = 32'h000145F3;
      5'd14: r = 32'h0000A2FA;  5'd15: r = 32'h0000517D;
      5'd16: r = 32'h000028BE;  5'd17: r = 32'h0000145F;
      5'd18: r = 32'h00000A30;  5'd19: r = 32'h00000518;
      5'd20: r = 32'h0000028C;  5'd21: r = 32'h00000146;
      5'd22: r = 32'h000000A3;  5'd23: r = 32'h00000051;
      5'd24: r = 32'h00000029;  5'd25: r = 32'h00000014;
      5'd26: r = 32'h0000000A;  5'd27: r = 32'h00000005;
      5'd28: r = 32'h00000003;  5'd29: r = 32'h00000001;
      default: r = 32'h0;
    endcase
    return r;
  endfunction

  // Saturate a wide signed value to 32 bits
  function automatic logic signed [31:0] sat32(input logic signed [43:0] v);
    logic signed [31:0] r;
    if (v > 44'sd2147483647) r = 32'sh7FFFFFFF;
    else if (v < -44'sd2147483648) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

endpackage

[design/umpj_if.sv]
// ----------------------------------------------------------------------------
// umpj_if
// Valid/ready channel carrying one word of a given type.
// ----------------------------------------------------------------------------
interface umpj_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[design/umpj_mag_scale.sv]
// ----------------------------------------------------------------------------
// umpj_mag_scale
// Signed value times an unsigned step, its magnitude shifted and capped.
// Two registered stages: split multiply, then recombine, shift and cap.
// ----------------------------------------------------------------------------
module umpj_mag_scale
  import umpj_pkg::*;
#(
  parameter int unsigned Shift = 46
) (
  input  logic               clk_i,
  input  logic               en_i,
  input  logic signed [63:0] a_i,
  input  logic        [31:0] b_i,
  output logic signed [41:0] p_o
);
  logic        neg_q;
  logic [63:0] lo_q, hi_q;
  logic [63:0] mag_a;
  logic [95:0] full;
  logic [95:0] shifted;
  logic [40:0] mag;

  assign mag_a = a_i[63] ? (64'd0 - a_i) : a_i;

  // Stage one: two 32x32 partial products
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      neg_q <= a_i[63];
      lo_q  <= 64'(mag_a[31:0]) * 64'(b_i);
      hi_q  <= 64'(mag_a[63:32]) * 64'(b_i);
    end
  end

  // Stage two: recombine, shift, cap
  assign full    = {hi_q, 32'd0} + {32'd0, lo_q};
  assign shifted = full >> Shift;
  always_comb begin
    if (shifted > 96'(MagCap)) mag = MagCap;
    else mag = shifted[40:0];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_o <= neg_q ? (42'sd0 - $signed({1'b0, mag})) : $signed({1'b0, mag});
    end
  end
endmodule

[design/unicycle_motion_predict_jacobian.sv]
// ----------------------------------------------------------------------------
// unicycle_motion_predict_jacobian
// EKF prediction step for a constant speed, constant turn rate vehicle.
// ----------------------------------------------------------------------------
// A word enters every cycle unless a stalled output holds the pipeline; the
// pipeline is one heading reduction multiply, a CORDIC start stage and one
// stage per CORDIC rotation (rotations are capped at 30), the sine/cosine
// products by speed, two stages of step scaling and a final sum and
// saturation stage. A stall at the output freezes the whole pipeline, so
// words are neither lost nor repeated. The user must write noise means on the
// configuration channel only while the block is idle; the block itself does
// not enforce this. Unknown indexes are ignored.
// ----------------------------------------------------------------------------
module unicycle_motion_predict_jacobian
  import umpj_pkg::*;
#(
  parameter int unsigned FRAC_BITS    = 16,
  parameter int unsigned CORDIC_STEPS = 18
) (
  input  logic clk_i,
  input  logic rst_ni,
  umpj_if.sink   cfg_i,
  umpj_if.sink   in_i,
  umpj_if.source out_o
);
  localparam int unsigned Steps = (CORDIC_STEPS < MaxSteps) ? CORDIC_STEPS : MaxSteps;
  localparam int unsigned Depth = Steps + 6;

  logic signed [31:0] mu_x_q, mu_y_q, mu_h_q, mu_v_q, mu_w_q;
  logic [Depth-1:0] vld_q;
  logic adv;

  // Advance when the output slot is free or being taken
  assign adv         = !vld_q[Depth-1] || out_o.ready;
  assign in_i.ready  = adv;
  assign cfg_i.ready = 1'b1;
  assign out_o.valid = vld_q[Depth-1];

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mu_x_q <= '0; mu_y_q <= '0; mu_h_q <= '0; mu_v_q <= '0; mu_w_q <= '0;
    end else if (cfg_i.valid) begin
      case (cfg_i.data.index)
        REG_MU_X:       mu_x_q <= cfg_i.data.data;
        REG_MU_Y:       mu_y_q <= cfg_i.data.data;
        REG_MU_HEADING: mu_h_q <= cfg_i.data.data;
        REG_MU_SPEED:   mu_v_q <= cfg_i.data.data;
        REG_MU_TURN:    mu_w_q <= cfg_i.data.data;
        default: ;
      endcase
    end
  end

  // Valid bits travel with the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld_q <= '0;
    else if (adv) vld_q <= {vld_q[Depth-2:0], in_i.valid};
  end

  // Input fields delayed alongside the sine/cosine path
  in_word_t inp_q [Depth-1];
  always_ff @(posedge clk_i) begin
    if (adv) begin
      inp_q[0] <= in_i.data;
      for (int k = 1; k < Depth - 1; k++) inp_q[k] <= inp_q[k-1];
    end
  end

  // Stage zero: heading times 1/(2 pi)
  logic [63:0] hprod_q;
  always_ff @(posedge clk_i) begin
    if (adv) hprod_q <= 64'($signed(in_i.data.heading)) * 64'(InvTwoPiQ32);
  end

  // Half-plane fold
  logic [31:0] p_turn, p_fold;
  logic flip;
  assign p_turn = hprod_q[FRAC_BITS +: 32];
  assign flip   = p_turn[31] ^ p_turn[30];
  assign p_fold = flip ? (p_turn + 32'h80000000) : p_turn;

  // CORDIC rotation stages
  logic signed [33:0] cx_q [Steps+1];
  logic signed [33:0] cy_q [Steps+1];
  logic signed [33:0] cz_q [Steps+1];
  logic               cf_q [Steps+1];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      cx_q[0] <= CordicGain;
      cy_q[0] <= '0;
      cz_q[0] <= 34'($signed(p_fold));
      cf_q[0] <= flip;
      for (int i = 0; i < Steps; i++) begin
        if (!cz_q[i][33]) begin
          cx_q[i+1] <= cx_q[i] - (cy_q[i] >>> i);
          cy_q[i+1] <= cy_q[i] + (cx_q[i] >>> i);
          cz_q[i+1] <= cz_q[i] - $signed({2'b00, atan_turns(5'(i))});
        end else begin
          cx_q[i+1] <= cx_q[i] + (cy_q[i] >>> i);
          cy_q[i+1] <= cy_q[i] - (cx_q[i] >>> i);
          cz_q[i+1] <= cz_q[i] + $signed({2'b00, atan_turns(5'(i))});
        end
        cf_q[i+1] <= cf_q[i];
      end
    end
  end

  // Fold back and multiply by speed
  logic signed [33:0] cos_v, sin_v;
  logic signed [63:0] vc_q, vs_q, c_q, s_q;
  in_word_t ip;
  assign ip    = inp_q[Steps+1];
  assign cos_v = cf_q[Steps] ? -cx_q[Steps] : cx_q[Steps];
  assign sin_v = cf_q[Steps] ? -cy_q[Steps] : cy_q[Steps];
  always_ff @(posedge clk_i) begin
    if (adv) begin
      vc_q <= 64'(ip.speed) * 64'(cos_v);
      vs_q <= 64'(ip.speed) * 64'(sin_v);
      c_q  <= 64'(cos_v);
      s_q  <= 64'(sin_v);
    end
  end

  // Step scaling, two stages each
  logic [31:0] dt_s;
  logic signed [41:0] vc_dt, vs_dt, c_dt, s_dt, w_dt;
  assign dt_s = inp_q[Steps+2].time_step;

  umpj_mag_scale #(.Shift(FRAC_BITS + 30)) u_vc (
    .clk_i, .en_i(adv), .a_i(vc_q), .b_i(dt_s), .p_o(vc_dt));
  umpj_mag_scale #(.Shift(FRAC_BITS + 30)) u_vs (
    .clk_i, .en_i(adv), .a_i(vs_q), .b_i(dt_s), .p_o(vs_dt));
  umpj_mag_scale #(.Shift(30)) u_c (
    .clk_i, .en_i(adv), .a_i(c_q), .b_i(dt_s), .p_o(c_dt));
  umpj_mag_scale #(.Shift(30)) u_s (
    .clk_i, .en_i(adv), .a_i(s_q), .b_i(dt_s), .p_o(s_dt));
  umpj_mag_scale #(.Shift(FRAC_BITS)) u_w (
    .clk_i, .en_i(adv), .a_i(64'(inp_q[Steps+2].turn_rate)), .b_i(dt_s), .p_o(w_dt));

  // Sum, saturate and hold the result word
  in_word_t iz;
  out_word_t res_q;
  assign iz = inp_q[Depth-2];
  always_ff @(posedge clk_i) begin
    if (adv) begin
      res_q.next_x <= sat32(44'(iz.pos_x) + 44'(vc_dt) + 44'(mu_x_q));
      res_q.next_y <= sat32(44'(iz.pos_y) + 44'(vs_dt) + 44'(mu_y_q));
      res_q.next_heading <= sat32(44'(iz.heading) + 44'(w_dt) + 44'(mu_h_q));
      res_q.next_speed <= sat32(44'(iz.speed) + 44'(mu_v_q));
      res_q.next_turn <= sat32(44'(iz.turn_rate) + 44'(mu_w_q));
      res_q.jac_x_by_heading <= sat32(44'sd0 - 44'(vs_dt));
      res_q.jac_x_by_speed <= sat32(44'(c_dt));
      res_q.jac_y_by_heading <= sat32(44'(vc_dt));
      res_q.jac_y_by_speed <= sat32(44'(s_dt));
      res_q.jac_heading_by_turn <= iz.time_step[31] ? 31'h7FFFFFFF : iz.time_step[30:0];
    end
  end
  assign out_o.data = res_q;

  // A stalled result holds its word
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && !out_o.ready |=> out_o.valid && $stable(out_o.data))
    else $error("result changed under stall");
  // The input is taken whenever the output is free
  a_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_o.valid |-> in_i.ready)
    else $error("pipeline blocked without a pending result");
  // Time step Jacobian never exceeds its 31-bit maximum
  a_dt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> out_o.data.jac_heading_by_turn <= 31'h7FFFFFFF)
    else $error("bad step entry");
endmodule
